// File: design/rdsc_pkg.sv
// Shared types, constants and helpers for the radix digit sum converter.
package rdsc_pkg;

	localparam int unsigned RADIX_W = 5;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned CHAR_W = 7;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	localparam logic [DIGIT_W-1:0] DEC_LIMIT = 4'd10;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_LETTER_A = 7'h41;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	typedef struct packed {
		logic                done;
		logic                busy;
		logic [DIGIT_W-1:0]  rem;
	} div_stat_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DEC_LIMIT) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_LETTER_A + CHAR_W'(d - DEC_LIMIT);
		end
		return c;
	endfunction

endpackage

// File: design/rdsc_divider.sv
// Bit-serial restoring divider of a wide value by a small radix.
module rdsc_divider #(
	parameter int unsigned SUM_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [SUM_BITS-1:0]            dividend,
	input  logic [rdsc_pkg::RADIX_W-1:0]   divisor,
	output logic [SUM_BITS-1:0]            quotient,
	output rdsc_pkg::div_stat_t            stat
);

	localparam int unsigned CW = $clog2(SUM_BITS);

	logic                         busy_q;
	logic                         done_q;
	logic [CW-1:0]                cnt_q;
	logic [SUM_BITS-1:0]          quo_q;
	logic [rdsc_pkg::DIGIT_W-1:0] rem_q;
	logic [rdsc_pkg::RADIX_W-1:0] trial;
	logic [rdsc_pkg::RADIX_W-1:0] diff;
	logic                         ge;

	assign trial = {rem_q, quo_q[SUM_BITS-1]};
	assign ge = (trial >= divisor);
	assign diff = trial - divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(SUM_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_BITS-2:0], ge};
			rem_q <= ge ? diff[rdsc_pkg::DIGIT_W-1:0] : trial[rdsc_pkg::DIGIT_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign stat.done = done_q;
	assign stat.busy = busy_q;
	assign stat.rem = rem_q;

endmodule

// File: design/radix_digit_sum_converter.sv
// Top level: folds base-N digits into numbers, sums them and emits the sum in base N.
//
// channel | dir | tdata                              | tlast         | tuser
// s_axis  | in  | [3:0] digit_value                  | end_of_number | end_of_sum
// m_axis  | out | [3:0] sum_digit, [10:4] digit_char | last_digit    | overflow
// cfg     | in  | cfg_wr_data radix on cfg_wr_en     |               |
//
// A digit that ends a number is folded in and then added to the sum in ST_ADD.
// At the end of a sum the shared bit-serial divider runs once per output digit, then
// each digit is read from the remainder store in ST_EMIT_RD and shown in ST_EMIT_OUT.
// Reset clears the sum, the operand, the overflow flag and the sequencer; radix returns to 10.
// Input is not ready from the end of a number until its add is done, and during a whole
// conversion and emission; a stalled output holds the sequencer in place.
module radix_digit_sum_converter #(
	parameter int unsigned SUM_BITS = 32,
	parameter int unsigned MAX_DIGITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rdsc_pkg::RADIX_W-1:0]  cfg_wr_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // digit_value, zero fill
	input  logic                          s_axis_tlast,
	input  logic                          s_axis_tuser,  // end_of_sum
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [15:0]                   m_axis_tdata,  // sum_digit, digit_char, zero fill
	output logic                          m_axis_tlast,
	output logic                          m_axis_tuser   // overflow
);

	localparam int unsigned AW = $clog2(MAX_DIGITS);
	localparam int unsigned CNW = $clog2(MAX_DIGITS + 1);
	localparam int unsigned PW = SUM_BITS + rdsc_pkg::RADIX_W;

	rdsc_pkg::state_t state_q, state_d;

	logic [rdsc_pkg::RADIX_W-1:0] radix_q;
	logic [rdsc_pkg::RADIX_W-1:0] radix_eff;
	logic [SUM_BITS-1:0]          operand_q;
	logic [SUM_BITS-1:0]          sum_q;
	logic [SUM_BITS-1:0]          v_q;
	logic                         ovf_q;
	logic                         eos_q;
	logic [CNW-1:0]               cnt_q;
	logic [AW-1:0]                idx_q;
	logic [rdsc_pkg::DIGIT_W-1:0] rd_q;
	logic [rdsc_pkg::DIGIT_W-1:0] rem_mem [MAX_DIGITS];

	logic [PW-1:0]                fold;
	logic [SUM_BITS:0]            add_sum;
	logic                         in_acc;
	logic                         out_acc;
	logic                         div_start;
	logic                         more_digits;
	logic [SUM_BITS-1:0]          div_quo;
	rdsc_pkg::div_stat_t          div_stat;

	assign radix_eff = (radix_q < rdsc_pkg::RADIX_MIN) ? rdsc_pkg::RADIX_MIN :
		(radix_q > rdsc_pkg::RADIX_MAX) ? rdsc_pkg::RADIX_MAX : radix_q;

	assign fold = PW'(operand_q) * PW'(radix_eff) + PW'(s_axis_tdata[rdsc_pkg::DIGIT_W-1:0]);
	assign add_sum = {1'b0, sum_q} + {1'b0, operand_q};
	assign more_digits = (div_quo != '0) &&
		(({1'b0, cnt_q} + 1'b1) < (CNW + 1)'(MAX_DIGITS));

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	rdsc_divider #(
		.SUM_BITS(SUM_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(v_q),
		.divisor(radix_eff),
		.quotient(div_quo),
		.stat(div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			rdsc_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && (s_axis_tlast || s_axis_tuser)) begin
					state_d = rdsc_pkg::ST_ADD;
				end
			end
			rdsc_pkg::ST_ADD: begin
				state_d = eos_q ? rdsc_pkg::ST_DIV_START : rdsc_pkg::ST_IDLE;
			end
			rdsc_pkg::ST_DIV_START: begin
				div_start = 1'b1;
				state_d = rdsc_pkg::ST_DIV_WAIT;
			end
			rdsc_pkg::ST_DIV_WAIT: begin
				if (div_stat.done) begin
					state_d = more_digits ? rdsc_pkg::ST_DIV_START : rdsc_pkg::ST_EMIT_RD;
				end
			end
			rdsc_pkg::ST_EMIT_RD: begin
				state_d = rdsc_pkg::ST_EMIT_OUT;
			end
			rdsc_pkg::ST_EMIT_OUT: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready) begin
					state_d = (idx_q == '0) ? rdsc_pkg::ST_IDLE : rdsc_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_d = rdsc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rdsc_pkg::RADIX_RESET;
			operand_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
			eos_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				radix_q <= cfg_wr_data;
			end
			if (in_acc) begin
				operand_q <= fold[SUM_BITS-1:0];
				eos_q <= s_axis_tuser;
				if (fold[PW-1:SUM_BITS] != '0) begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == rdsc_pkg::ST_ADD) begin
				sum_q <= add_sum[SUM_BITS-1:0];
				operand_q <= '0;
				cnt_q <= '0;
				if (add_sum[SUM_BITS]) begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == rdsc_pkg::ST_DIV_WAIT && div_stat.done) begin
				cnt_q <= cnt_q + 1'b1;
				idx_q <= cnt_q[AW-1:0];
			end
			if (out_acc) begin
				if (idx_q == '0) begin
					sum_q <= '0;
					ovf_q <= 1'b0;
					cnt_q <= '0;
				end else begin
					idx_q <= idx_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rdsc_pkg::ST_ADD) begin
			v_q <= add_sum[SUM_BITS-1:0];
		end else if (state_q == rdsc_pkg::ST_DIV_WAIT && div_stat.done) begin
			v_q <= div_quo;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rdsc_pkg::ST_DIV_WAIT && div_stat.done) begin
			rem_mem[cnt_q[AW-1:0]] <= div_stat.rem;
		end
		if (state_q == rdsc_pkg::ST_EMIT_RD) begin
			rd_q <= rem_mem[idx_q];
		end
	end

	assign m_axis_tdata = {5'b0, rdsc_pkg::digit_char(rd_q), rd_q};
	assign m_axis_tlast = (idx_q == '0);
	assign m_axis_tuser = ovf_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("output valid while input is ready");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNW'(MAX_DIGITS))
		else $error("remainder count past store depth");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_axis_tlast) |=> (s_axis_tready && sum_q == '0 && !ovf_q))
		else $error("sum state not cleared after last digit");

	a_wait_has_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rdsc_pkg::ST_DIV_WAIT) |-> (div_stat.busy || div_stat.done))
		else $error("waiting on an idle divider");

endmodule

// File: tb/radix_sum_checker.sv
// Checker that predicts the sum digits of the radix digit sum converter and compares them.
module radix_sum_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rdsc_pkg::RADIX_W-1:0]  cfg_wr_data,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // digit_value, zero fill
	input  logic                          s_axis_tlast,
	input  logic                          s_axis_tuser,  // end_of_sum
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [15:0]                   m_axis_tdata,  // sum_digit, digit_char, zero fill
	input  logic                          m_axis_tlast,
	input  logic                          m_axis_tuser,  // overflow
	output int                            fail_count,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import rdsc_pkg::*;

	localparam int unsigned ACC_BITS = 32;
	localparam int unsigned DIGITS_MAX = 32;
	localparam int unsigned MAX_REPORTS = 50;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic [CHAR_W-1:0]  ascii;
		logic               last;
		logic               wrapped;
	} sum_digit_t;

	logic [RADIX_W-1:0]  base_reg;
	logic [ACC_BITS-1:0] operand_acc;
	logic [ACC_BITS-1:0] sum_acc;
	logic                wrap_seen;
	sum_digit_t          sum_digits_due[$];

	function automatic logic [RADIX_W-1:0] clamp_base(input logic [RADIX_W-1:0] b);
		logic [RADIX_W-1:0] r;
		if (b < RADIX_MIN) begin
			r = RADIX_MIN;
		end else if (b > RADIX_MAX) begin
			r = RADIX_MAX;
		end else begin
			r = b;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (fail_count < MAX_REPORTS) begin
			$display("%0t: mismatch on %s, got %0h, want %0h", $realtime, what, got, want);
		end
		fail_count++;
	endtask

	task automatic fold_digit(input logic [DIGIT_W-1:0] d, input logic eon, input logic eos);
		logic [RADIX_W-1:0]    b;
		logic [2*ACC_BITS-1:0] product;
		logic [ACC_BITS:0]     total;
		logic [ACC_BITS-1:0]   rest;
		logic [ACC_BITS-1:0]   divisor;
		logic [DIGIT_W-1:0]    rems[DIGITS_MAX];
		sum_digit_t            item;
		int                    n;
		int                    k;
		b = clamp_base(base_reg);
		divisor = {{(ACC_BITS-RADIX_W){1'b0}}, b};
		product = {{ACC_BITS{1'b0}}, operand_acc} * {{ACC_BITS{1'b0}}, divisor}
			+ {{(2*ACC_BITS-DIGIT_W){1'b0}}, d};
		if (product[2*ACC_BITS-1:ACC_BITS] != '0) begin
			wrap_seen = 1'b1;
		end
		operand_acc = product[ACC_BITS-1:0];
		if (eon || eos) begin
			total = {1'b0, sum_acc} + {1'b0, operand_acc};
			if (total[ACC_BITS]) begin
				wrap_seen = 1'b1;
			end
			sum_acc = total[ACC_BITS-1:0];
			operand_acc = '0;
		end
		if (eos) begin
			rest = sum_acc;
			n = 0;
			do begin
				rems[n] = DIGIT_W'(rest % divisor);
				rest = rest / divisor;
				n++;
			end while (rest != '0 && n < DIGITS_MAX);
			for (k = n - 1; k >= 0; k--) begin
				item.digit = rems[k];
				if (rems[k] < DEC_LIMIT) begin
					item.ascii = CHAR_ZERO + CHAR_W'(rems[k]);
				end else begin
					item.ascii = CHAR_LETTER_A + CHAR_W'(rems[k] - DEC_LIMIT);
				end
				item.last = (k == 0);
				item.wrapped = wrap_seen;
				sum_digits_due.push_back(item);
			end
			sum_acc = '0;
			operand_acc = '0;
			wrap_seen = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sum_digit_t want;
		if (!arst_n) begin
			base_reg = RADIX_RESET;
			operand_acc = '0;
			sum_acc = '0;
			wrap_seen = 1'b0;
			sum_digits_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en) begin
				base_reg = cfg_wr_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				fold_digit(s_axis_tdata[DIGIT_W-1:0], s_axis_tlast, s_axis_tuser);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (sum_digits_due.size() == 0) begin
					report_mismatch("unexpected item", m_axis_tdata, '0);
				end else begin
					want = sum_digits_due.pop_front();
					if (m_axis_tdata[3:0] != want.digit) begin
						report_mismatch("sum_digit", 16'(m_axis_tdata[3:0]), 16'(want.digit));
					end
					if (m_axis_tdata[10:4] != want.ascii) begin
						report_mismatch("digit_char", 16'(m_axis_tdata[10:4]), 16'(want.ascii));
					end
					if (m_axis_tdata[15:11] != '0) begin
						report_mismatch("tdata fill", 16'(m_axis_tdata[15:11]), '0);
					end
					if (m_axis_tlast != want.last) begin
						report_mismatch("last_digit", 16'(m_axis_tlast), 16'(want.last));
					end
					if (m_axis_tuser != want.wrapped) begin
						report_mismatch("overflow", 16'(m_axis_tuser), 16'(want.wrapped));
					end
				end
			end
			pending = sum_digits_due.size();
		end
	end

endmodule

// File: tb/tb_radix_digit_sum_converter.sv
// Testbench top that drives digit items and radix writes into the converter and gives the verdict.
module tb_radix_digit_sum_converter;
	timeunit 1ns;
	timeprecision 1ps;
	import rdsc_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 23;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [RADIX_W-1:0]  cfg_wr_data;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata;   // digit_value, zero fill
	logic                s_axis_tlast;
	logic                s_axis_tuser;   // end_of_sum
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [15:0]         m_axis_tdata;   // sum_digit, digit_char, zero fill
	logic                m_axis_tlast;
	logic                m_axis_tuser;   // overflow

	int fail_count;
	int pending;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int digit_ceiling = 10;
	int items_sent = 0;
	bit hold_req = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	radix_digit_sum_converter u_top (.*);

	radix_sum_checker u_checker (.*);

	task automatic send_digit(input logic [DIGIT_W-1:0] d, input logic eon, input logic eos);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < tx_idle_pct && gap < 20) begin
			gap++;
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, d};
		s_axis_tlast <= eon;
		s_axis_tuser <= eos;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_radix(input logic [RADIX_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (value < RADIX_MIN) begin
			digit_ceiling = 2;
		end else if (value > RADIX_MAX) begin
			digit_ceiling = 16;
		end else begin
			digit_ceiling = int'(value);
		end
	endtask

	task automatic send_random_sum();
		int operands;
		int len;
		int pick;
		int o;
		int i;
		logic [DIGIT_W-1:0] d;
		logic eon;
		logic eos;
		operands = $urandom_range(1, 3);
		for (o = 0; o < operands; o++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = $urandom_range(1, 4);
			end else if (pick < 95) begin
				len = $urandom_range(5, 12);
			end else begin
				len = $urandom_range(13, 34);
			end
			for (i = 0; i < len; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					d = DIGIT_W'($urandom_range(0, 15));
				end else begin
					d = DIGIT_W'($urandom_range(0, digit_ceiling - 1));
				end
				eon = (i == len - 1);
				eos = eon && (o == operands - 1);
				// Stray end marks inside a sum break the operand and sum framing.
				if (!eos && $urandom_range(0, 99) < 8) begin
					eon = 1'($urandom_range(0, 1));
					eos = 1'($urandom_range(0, 1));
				end
				send_digit(d, eon, eos);
			end
		end
	endtask

	task automatic run_phase(input logic [RADIX_W-1:0] base, input int tx_pct, input int rx_pct,
			input bit squeeze);
		drain();
		write_radix(base);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		hold_req = squeeze;
		items_sent = 0;
		while (items_sent < PHASE_ITEMS) begin
			send_random_sum();
		end
	endtask

	initial begin
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (hold_req && !hold_taken && m_axis_tvalid) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= RADIX_RESET;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tlast <= 1'b0;
		s_axis_tuser <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The reset radix of ten: a zero sum, a digit above the radix that ends the sum
		// without ending its number, a multi-operand sum and an operand that wraps.
		send_digit(4'd0, 1'b1, 1'b1);
		send_digit(4'd15, 1'b0, 1'b1);
		send_digit(4'd3, 1'b1, 1'b0);
		send_digit(4'd4, 1'b0, 1'b0);
		send_digit(4'd5, 1'b0, 1'b1);
		repeat (10) send_digit(4'd9, 1'b0, 1'b0);
		send_digit(4'd9, 1'b1, 1'b1);
		drain();

		// The largest hex operand plus one wraps the sum to zero.
		write_radix(RADIX_MAX);
		repeat (7) send_digit(4'd15, 1'b0, 1'b0);
		send_digit(4'd15, 1'b1, 1'b0);
		send_digit(4'd1, 1'b1, 1'b1);

		run_phase(5'd2, 0, 0, 1'b0);
		run_phase(5'd16, 48, 0, 1'b0);
		run_phase(5'd0, 0, 48, 1'b0);
		run_phase(5'd31, 35, 35, 1'b0);
		run_phase(5'd7, 0, 0, 1'b1);
		run_phase(5'd1, 48, 0, 1'b0);
		run_phase(5'd3, 0, 48, 1'b0);
		run_phase(5'd17, 35, 35, 1'b0);
		run_phase(5'd10, 0, 0, 1'b0);
		drain();

		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
